// ===== hw/rtl/tksk_pkg.sv =====
// Shared types and constants for the top-k score keeper.
// Field widths, operation codes and the cell control beat.
// No dependencies.
package tksk_pkg;

    localparam int MAX_KEEP_DEF = 16;
    localparam int ID_W         = 25;
    localparam int SCORE_W      = 16;
    localparam int RANK_W       = 4;
    localparam int KEEP_W       = 5;
    localparam int OP_W         = 2;

    localparam logic signed [SCORE_W-1:0] EMPTY_SCORE = -16'sd16384;

    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic ins_en;     // add beat in this cycle
        logic filled;     // slot holds an added pair
        logic take_new;   // slot above keeps its entry, or this is the head
    } cell_ctl_t;

endpackage

// ===== hw/rtl/top_k_score_keeper.sv =====
// Top level of the top-k score keeper: command port, fill count, read-out sequencer.
// Depends on tksk_pkg and tksk_cell.
//
// channel   direction  handshake                     payload
// command   in         start & !busy                 operation, item_id, item_score
// result    out        done (one cycle, no stall)    rank, entry_id, entry_score, filled, last
// config    in         keep_count_we                 keep_count
//
// Add and clear leave busy low; a new command is taken in the next cycle.
// Read holds busy while it steps through the effective keep_count (1 to MAX_KEEP) slots, one
//   result beat per slot; the read state and then the beat payload are registered before the
//   first beat appears. The row of slot cells performs the insert of an add.
// Reset empties the list and sets keep_count to 5; no clearing pass is needed.
// The receiver cannot stall: each result beat shows for exactly one cycle.
module top_k_score_keeper
    import tksk_pkg::*;
#(
    parameter int MAX_KEEP = MAX_KEEP_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [ID_W-1:0]           item_id,
    input  logic signed [SCORE_W-1:0] item_score,
    input  logic                      keep_count_we,
    input  logic [KEEP_W-1:0]         keep_count,
    output logic                      done,
    output logic [RANK_W-1:0]         rank,
    output logic [ID_W-1:0]           entry_id,
    output logic signed [SCORE_W-1:0] entry_score,
    output logic                      filled,
    output logic                      last
);

    localparam int CNT_W = $clog2(MAX_KEEP + 1);
    localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [KEEP_W-1:0]  keep_reg;
    logic [KEEP_W-1:0]  keep_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic [CNT_W-1:0]   rd_idx_next;
    logic [CNT_W-1:0]   eff_keep;
    logic [CNT_W-1:0]   new_eff;
    logic               accept;
    logic               rd_last;

    logic                      done_reg;
    logic [RANK_W-1:0]         rank_reg;
    logic [ID_W-1:0]           id_out_reg;
    logic signed [SCORE_W-1:0] score_out_reg;
    logic                      filled_reg;
    logic                      last_reg;

    logic [ID_W-1:0]           slot_id    [MAX_KEEP];
    logic signed [SCORE_W-1:0] slot_score [MAX_KEEP];
    logic                      slot_ge    [MAX_KEEP];

    function automatic logic [CNT_W-1:0] sat_keep(input logic [KEEP_W-1:0] kc);
        logic [CNT_W-1:0] r;
        if (kc == '0)
            r = CNT_W'(1);
        else if (int'(kc) > MAX_KEEP)
            r = CNT_W'(MAX_KEEP);
        else
            r = CNT_W'(kc);
        return r;
    endfunction

    assign eff_keep = sat_keep(keep_reg);
    assign new_eff  = sat_keep(keep_count);
    assign busy     = (state_reg == ST_READ);
    assign accept   = start && !busy;
    assign rd_last  = ({1'b0, rd_idx_reg} + 1'b1) == {1'b0, eff_keep};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);
            cell_ctl_t                 ctl;
            logic [ID_W-1:0]           prev_id;
            logic signed [SCORE_W-1:0] prev_score;

            assign ctl.ins_en = accept && (operation == OP_ADD);
            assign ctl.filled = IDX < fill_reg;
            if (gi == 0)
            begin : g_head
                assign ctl.take_new = 1'b1;
                assign prev_id      = '0;
                assign prev_score   = EMPTY_SCORE;
            end
            else
            begin : g_body
                assign ctl.take_new = slot_ge[gi-1];
                assign prev_id      = slot_id[gi-1];
                assign prev_score   = slot_score[gi-1];
            end

            tksk_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_id     (item_id),
                .new_score  (item_score),
                .prev_id    (prev_id),
                .prev_score (prev_score),
                .id         (slot_id[gi]),
                .score      (slot_score[gi]),
                .ge         (slot_ge[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        keep_next   = keep_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        if (keep_count_we)
        begin
            keep_next = keep_count;
            if (fill_reg > new_eff)
                fill_next = new_eff;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation)
                        OP_ADD:
                            fill_next = (fill_reg < eff_keep) ? fill_reg + 1'b1 : eff_keep;
                        OP_CLEAR:
                            fill_next = '0;
                        OP_READ:
                        begin
                            state_next  = ST_READ;
                            rd_idx_next = '0;
                        end
                        default:
                            ;
                    endcase
                end
            end
            ST_READ:
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            keep_reg   <= KEEP_W'(5);
            fill_reg   <= '0;
            rd_idx_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            keep_reg   <= keep_next;
            fill_reg   <= fill_next;
            rd_idx_reg <= rd_idx_next;
            done_reg   <= busy;
        end
    end

    // hold the beat payload from the slot under the read index
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            rank_reg   <= RANK_W'(rd_idx_reg);
            filled_reg <= rd_idx_reg < fill_reg;
            last_reg   <= rd_last;
            if (rd_idx_reg < fill_reg)
            begin
                id_out_reg    <= slot_id[rd_idx_reg[IDX_W-1:0]];
                score_out_reg <= slot_score[rd_idx_reg[IDX_W-1:0]];
            end
            else
            begin
                id_out_reg    <= '0;
                score_out_reg <= EMPTY_SCORE;
            end
        end
    end

    assign done        = done_reg;
    assign rank        = rank_reg;
    assign entry_id    = id_out_reg;
    assign entry_score = score_out_reg;
    assign filled      = filled_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= eff_keep)
        else $error("fill count exceeds kept count");

    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_READ))
        else $error("result beat without read");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && last |=> !done)
        else $error("beat after last");

    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(done) |-> rank == $past(rank) + 1'b1)
        else $error("rank did not advance");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == OP_ADD && !keep_count_we && fill_reg < eff_keep
        |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("add did not grow list");
`endif

endmodule

// ===== hw/rtl/tksk_cell.sv =====
// One slot of the insertion row: holds an id and a score.
// Uses tksk_pkg for widths and the control struct.
module tksk_cell
    import tksk_pkg::*;
(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic [ID_W-1:0]           new_id,
    input  logic signed [SCORE_W-1:0] new_score,
    input  logic [ID_W-1:0]           prev_id,
    input  logic signed [SCORE_W-1:0] prev_score,
    output logic [ID_W-1:0]           id,
    output logic signed [SCORE_W-1:0] score,
    output logic                      ge
);

    logic [ID_W-1:0]           id_reg;
    logic [ID_W-1:0]           id_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;

    assign ge = ctl.filled && (score_reg >= new_score);

    always_comb
    begin
        id_next    = id_reg;
        score_next = score_reg;
        if (ctl.ins_en && !ge)
        begin
            if (ctl.take_new)
            begin
                id_next    = new_id;
                score_next = new_score;
            end
            else
            begin
                id_next    = prev_id;
                score_next = prev_score;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

    assign id    = id_reg;
    assign score = score_reg;

endmodule

// ===== tb/testbench.sv =====
// Testbench for top_k_score_keeper: a directed table, then random add, clear, read and unused
// beats over several keep_count settings. A sorted-list predictor checks every read-out beat.
// Depends on tksk_pkg and the top_k_score_keeper RTL.
`timescale 1ns / 100ps

module testbench;
    import tksk_pkg::*;

    localparam int SLOTS        = MAX_KEEP_DEF;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 40;
    localparam int DIRECTED     = 21;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 20;
    localparam int SETTLE       = 4;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [ID_W-1:0] ID_MAX    = 25'h1FFFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 16'sh8000;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
        logic                      pinned;
        logic [ID_W-1:0]           head_id;
        logic signed [SCORE_W-1:0] head_score;
        logic                      head_filled;
    } stim_row_t;

    typedef struct packed {
        logic [RANK_W-1:0]         rank;
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
        logic                      filled;
        logic                      last;
    } slot_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [OP_W-1:0]           operation = OP_ADD;
    logic [ID_W-1:0]           item_id = '0;
    logic signed [SCORE_W-1:0] item_score = '0;
    logic                      keep_count_we = 1'b0;
    logic [KEEP_W-1:0]         keep_count = 5'd5;
    logic                      done;
    logic [RANK_W-1:0]         rank;
    logic [ID_W-1:0]           entry_id;
    logic signed [SCORE_W-1:0] entry_score;
    logic                      filled;
    logic                      last;

    logic [ID_W-1:0]           held_ids [0:SLOTS];
    logic signed [SCORE_W-1:0] held_scores [0:SLOTS];
    int                        held_count;
    logic [KEEP_W-1:0]         keep_reg;

    stim_row_t  head_pin;
    slot_beat_t expected_beats [$];
    int         errors = 0;
    int         quiet_cycles = 0;

    stim_row_t directed_rows [0:DIRECTED-1];
    logic [KEEP_W-1:0] keep_plan [0:PHASES-2] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd3};

    top_k_score_keeper uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .item_id      (item_id),
        .item_score   (item_score),
        .keep_count_we(keep_count_we),
        .keep_count   (keep_count),
        .done         (done),
        .rank         (rank),
        .entry_id     (entry_id),
        .entry_score  (entry_score),
        .filled       (filled),
        .last         (last)
    );

    always #1 clk = ~clk;

    function automatic int active_keep(logic [KEEP_W-1:0] kc);
        if (kc == 0)
            return 1;
        if (kc > SLOTS)
            return SLOTS;
        return int'(kc);
    endfunction

    task automatic empty_slots_from(int first);
        for (int i = first; i <= SLOTS; i++)
        begin
            held_ids[i]    = '0;
            held_scores[i] = EMPTY_SCORE;
        end
    endtask

    task automatic apply_keep(logic [KEEP_W-1:0] value);
        int k;
        keep_reg = value;
        k = active_keep(keep_reg);
        if (held_count > k)
            held_count = k;
        empty_slots_from(held_count);
    endtask

    // Insert below every entry with a greater or equal score; the spare slot takes the drop.
    task automatic insert_pair(logic [ID_W-1:0] id, logic signed [SCORE_W-1:0] score);
        int k;
        int n;
        int pos;
        k = active_keep(keep_reg);
        n = (held_count < k) ? held_count : k;
        pos = n;
        while (pos > 0 && held_scores[pos-1] < score)
        begin
            held_ids[pos]    = held_ids[pos-1];
            held_scores[pos] = held_scores[pos-1];
            pos--;
        end
        held_ids[pos]    = id;
        held_scores[pos] = score;
        held_count = (n < k) ? n + 1 : k;
    endtask

    task automatic queue_readout(stim_row_t pin);
        int k;
        slot_beat_t beat;
        k = active_keep(keep_reg);
        for (int r = 0; r < k; r++)
        begin
            beat.rank   = r[RANK_W-1:0];
            beat.filled = (r < held_count);
            beat.id     = beat.filled ? held_ids[r] : '0;
            beat.score  = beat.filled ? held_scores[r] : EMPTY_SCORE;
            beat.last   = (r + 1 == k);
            if (r == 0 && pin.pinned)
            begin
                beat.id     = pin.head_id;
                beat.score  = pin.head_score;
                beat.filled = pin.head_filled;
            end
            expected_beats.insert(expected_beats.size(), beat);
        end
    endtask

    task automatic compare_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_beat();
        slot_beat_t want;
        if (expected_beats.size() == 0)
        begin
            errors++;
            $display("%0t: result beat with nothing expected, expected none actual rank %0d id %0h",
                     $time, rank, entry_id);
            return;
        end
        want = expected_beats.pop_front();
        compare_field("rank", ID_W'(want.rank), ID_W'(rank));
        compare_field("entry_id", want.id, entry_id);
        compare_field("entry_score", ID_W'(want.score), ID_W'(entry_score));
        compare_field("filled", ID_W'(want.filled), ID_W'(filled));
        compare_field("last", ID_W'(want.last), ID_W'(last));
    endtask

    always @(posedge clk)
    begin : monitor
        bit moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (keep_count_we)
            begin
                apply_keep(keep_count);
                moved = 1'b1;
            end
            if (start && !busy)
            begin
                moved = 1'b1;
                case (operation)
                    OP_ADD:   insert_pair(item_id, item_score);
                    OP_CLEAR:
                    begin
                        held_count = 0;
                        empty_slots_from(0);
                    end
                    OP_READ:  queue_readout(head_pin);
                    default:  ;
                endcase
            end
            if (done)
            begin
                check_beat();
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(stim_row_t row);
        @(negedge clk);
        head_pin = row;
        start      <= 1'b1;
        operation  <= row.op;
        item_id    <= row.id;
        item_score <= row.score;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic hold_idle(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Drain all results, let the block settle, then write keep_count for one cycle.
    task automatic write_keep(logic [KEEP_W-1:0] value);
        @(negedge clk);
        start <= 1'b0;
        while (expected_beats.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
        keep_count_we <= 1'b1;
        keep_count    <= value;
        @(negedge clk);
        keep_count_we <= 1'b0;
    endtask

    function automatic stim_row_t random_row();
        stim_row_t row;
        int pick;
        row = '0;
        pick = $urandom_range(0, 99);
        if (pick < 74)
            row.op = OP_ADD;
        else if (pick < 91)
            row.op = OP_READ;
        else if (pick < 95)
            row.op = OP_CLEAR;
        else
            row.op = OP_UNUSED;
        row.id = ID_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            case ($urandom_range(0, 4))
                0:       row.score = EMPTY_SCORE;
                1:       row.score = -16'sd1;
                2:       row.score = 16'sd0;
                3:       row.score = 16'sd1;
                default: row.score = 16'sd16384;
            endcase
        end
        else if (pick < 40)
            row.score = $urandom_range(0, 1) ? SCORE_MAX : SCORE_MIN;
        else
            row.score = SCORE_W'($urandom);
        return row;
    endfunction

    task automatic random_phase(int beats);
        int left;
        int burst;
        stim_row_t row;
        left = beats;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                row = random_row();
                send_beat(row);
                if (row.op != OP_UNUSED)
                    left--;
                burst--;
            end
            if ($urandom_range(0, 3) != 0)
                hold_idle($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        keep_reg   = 5'd5;
        held_count = 0;
        head_pin   = '0;
        empty_slots_from(0);

        directed_rows = '{
            '{OP_READ,   25'd0,        16'sd0,      1'b1, 25'd0,     EMPTY_SCORE, 1'b0},
            '{OP_ADD,    ID_MAX,       SCORE_MAX,   1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'd0,        SCORE_MIN,   1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b1, ID_MAX,    SCORE_MAX,   1'b1},
            '{OP_ADD,    25'h0AAAAAA,  SCORE_MAX,   1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'h1555555,  16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'd5,        EMPTY_SCORE, 1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'd6,        16'sd100,    1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'd7,        SCORE_MIN,   1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'd8,        EMPTY_SCORE, 1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_UNUSED, ID_MAX,       -16'sd1,     1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b1, ID_MAX,    SCORE_MAX,   1'b1},
            '{OP_CLEAR,  25'd0,        16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b1, 25'd0,     EMPTY_SCORE, 1'b0},
            '{OP_ADD,    25'd123,      -16'sd1,     1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b1, 25'd123,   -16'sd1,     1'b1},
            '{OP_CLEAR,  25'd0,        16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_ADD,    25'h1000000,  16'sd1,      1'b0, 25'd0,     16'sd0,      1'b0},
            '{OP_READ,   25'd0,        16'sd0,      1'b0, 25'd0,     16'sd0,      1'b0}
        };

        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i]);
            hold_idle($urandom_range(0, 1));
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < PHASES - 1)
                write_keep(keep_plan[p]);
            else
                write_keep(KEEP_W'($urandom_range(0, 31)));
            random_phase(PHASE_BEATS);
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
